// ----- design/tcw_pkg.sv -----
// Shared types and constants of the text console character writer.
`timescale 1ns / 1ps

package tcw_pkg;

	localparam int COLS_DEFAULT = 80;
	localparam int ROWS_DEFAULT = 25;

	localparam int CELL_W = 16;
	localparam int ATTR_W = 8;
	localparam int CHAR_W = 8;
	localparam int IDX_W  = 11;
	localparam int OFFS_W = 11;

	localparam int TAB_STOP = 8;

	localparam logic [ATTR_W-1:0] RESET_ATTR  = 8'h0F;
	localparam logic [CHAR_W-1:0] GLYPH_BS    = 8'h08;
	localparam logic [CHAR_W-1:0] GLYPH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] GLYPH_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] GLYPH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] GLYPH_BLANK = 8'h20;

	localparam logic [CELL_W-1:0] RESET_BLANK = {RESET_ATTR, GLYPH_BLANK};

	typedef enum logic [1:0] {
		CMD_PRINT = 2'd0,
		CMD_CLEAR = 2'd1,
		CMD_READ  = 2'd2
	} cmd_t;

endpackage

// ----- design/tcw_screen_ram.sv -----
// Screen cell memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module tcw_screen_ram
	import tcw_pkg::*;
#(
	parameter int DEPTH = COLS_DEFAULT * ROWS_DEFAULT,
	parameter int AW    = $clog2(COLS_DEFAULT * ROWS_DEFAULT)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [CELL_W-1:0] wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output logic [CELL_W-1:0] rdata
);

	logic [CELL_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- design/tcw_ctrl.sv -----
// Command sequencer: cursor update, screen sweeps for clear and scroll, result register.
`timescale 1ns / 1ps

module tcw_ctrl
	import tcw_pkg::*;
#(
	parameter int COLS = COLS_DEFAULT,
	parameter int ROWS = ROWS_DEFAULT,
	parameter int AW   = $clog2(COLS_DEFAULT * ROWS_DEFAULT)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        cmd,
	input  logic [CHAR_W-1:0] char_code,
	input  logic [IDX_W-1:0]  cell_index,
	input  logic [ATTR_W-1:0] attr,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [OFFS_W-1:0] cursor_offset,
	output logic [CELL_W-1:0] cell_data,
	output logic              scrolled,
	output logic              mem_we,
	output logic [AW-1:0]     mem_waddr,
	output logic [CELL_W-1:0] mem_wdata,
	output logic              mem_re,
	output logic [AW-1:0]     mem_raddr,
	input  logic [CELL_W-1:0] mem_rdata
);

	localparam int CellCount = COLS * ROWS;
	localparam int CW = $clog2(COLS + TAB_STOP);
	localparam int RW = $clog2(ROWS + 1);
	localparam logic [AW-1:0] LastAddr    = AW'(CellCount - 1);
	localparam logic [AW-1:0] LastRowAddr = AW'((ROWS - 1) * COLS);

	typedef enum logic [2:0] {
		IDLE,
		READ,
		FILL,
		COPY,
		BLANK
	} state_t;

	state_t            state_q;
	logic              init_q;
	logic [AW-1:0]     cnt_q;
	logic [CW-1:0]     col_q;
	logic [RW-1:0]     row_q;
	logic              rd_ok_q;
	logic              copy_v_s1;
	logic [AW-1:0]     copy_addr_s1;
	logic              out_valid_q;
	logic [OFFS_W-1:0] cursor_offset_q;
	logic [CELL_W-1:0] cell_data_q;
	logic              scrolled_q;

	logic              accept;
	logic              wr_char;
	logic              do_scroll;
	logic [CW-1:0]     p_col;
	logic [RW-1:0]     p_row;
	logic [AW-1:0]     cur_addr;
	logic [AW-1:0]     next_addr;
	logic [CELL_W-1:0] blank;

	assign in_ready = (state_q == IDLE) && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;

	assign out_valid     = out_valid_q;
	assign cursor_offset = cursor_offset_q;
	assign cell_data     = cell_data_q;
	assign scrolled      = scrolled_q;

	assign blank     = init_q ? RESET_BLANK : {attr, GLYPH_BLANK};
	assign cur_addr  = AW'(row_q) * AW'(COLS) + AW'(col_q);
	assign next_addr = AW'(p_row) * AW'(COLS) + AW'(p_col);

	// Cursor movement for a print command.
	always_comb begin
		p_col   = col_q;
		p_row   = row_q;
		wr_char = 1'b0;
		if (char_code == GLYPH_BS && col_q != '0) begin
			p_col = col_q - 1'b1;
		end else if (char_code == GLYPH_TAB) begin
			p_col = (col_q + CW'(TAB_STOP)) & ~CW'(TAB_STOP - 1);
		end else if (char_code == GLYPH_LF) begin
			p_col = '0;
			p_row = row_q + 1'b1;
		end else if (char_code == GLYPH_CR) begin
			p_col = '0;
		end else begin
			wr_char = 1'b1;
			p_col   = col_q + 1'b1;
		end
		if (p_col >= CW'(COLS)) begin
			p_col = '0;
			p_row = p_row + 1'b1;
		end
		do_scroll = (p_row >= RW'(ROWS));
		if (do_scroll) begin
			p_row = RW'(ROWS - 1);
			p_col = '0;
		end
	end

	// Memory port steering.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cur_addr;
		mem_wdata = {attr, char_code};
		mem_re    = 1'b0;
		mem_raddr = AW'(cell_index);
		case (state_q)
			IDLE: begin
				if (accept && cmd == CMD_PRINT && wr_char) begin
					mem_we = 1'b1;
				end
				if (accept && cmd == CMD_READ) begin
					mem_re = 1'b1;
				end
			end
			FILL: begin
				mem_we    = 1'b1;
				mem_waddr = cnt_q;
				mem_wdata = blank;
			end
			COPY: begin
				mem_re    = 1'b1;
				mem_raddr = cnt_q;
				if (copy_v_s1) begin
					mem_we    = 1'b1;
					mem_waddr = copy_addr_s1;
					mem_wdata = mem_rdata;
				end
			end
			BLANK: begin
				mem_we = 1'b1;
				if (copy_v_s1) begin
					mem_waddr = copy_addr_s1;
					mem_wdata = mem_rdata;
				end else begin
					mem_waddr = cnt_q;
					mem_wdata = blank;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= FILL;
			init_q          <= 1'b1;
			cnt_q           <= '0;
			col_q           <= '0;
			row_q           <= '0;
			rd_ok_q         <= 1'b0;
			copy_v_s1       <= 1'b0;
			copy_addr_s1    <= '0;
			out_valid_q     <= 1'b0;
			cursor_offset_q <= '0;
			cell_data_q     <= '0;
			scrolled_q      <= 1'b0;
		end else begin
			copy_v_s1 <= 1'b0;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				IDLE: begin
					if (accept) begin
						case (cmd)
							CMD_PRINT: begin
								col_q <= p_col;
								row_q <= p_row;
								if (do_scroll) begin
									cnt_q   <= AW'(COLS);
									state_q <= COPY;
								end else begin
									out_valid_q     <= 1'b1;
									cursor_offset_q <= OFFS_W'(next_addr);
									cell_data_q     <= '0;
									scrolled_q      <= 1'b0;
								end
							end
							CMD_CLEAR: begin
								col_q   <= '0;
								row_q   <= '0;
								cnt_q   <= '0;
								state_q <= FILL;
							end
							CMD_READ: begin
								rd_ok_q <= (32'(cell_index) < 32'(CellCount));
								state_q <= READ;
							end
							default: begin
								out_valid_q     <= 1'b1;
								cursor_offset_q <= OFFS_W'(cur_addr);
								cell_data_q     <= '0;
								scrolled_q      <= 1'b0;
							end
						endcase
					end
				end
				READ: begin
					out_valid_q     <= 1'b1;
					cursor_offset_q <= OFFS_W'(cur_addr);
					cell_data_q     <= rd_ok_q ? mem_rdata : '0;
					scrolled_q      <= 1'b0;
					state_q         <= IDLE;
				end
				FILL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LastAddr) begin
						init_q  <= 1'b0;
						state_q <= IDLE;
						// The pass after reset gives no result; a clear command does.
						if (!init_q) begin
							out_valid_q     <= 1'b1;
							cursor_offset_q <= OFFS_W'(cur_addr);
							cell_data_q     <= '0;
							scrolled_q      <= 1'b0;
						end
					end
				end
				COPY: begin
					copy_v_s1    <= 1'b1;
					copy_addr_s1 <= cnt_q - AW'(COLS);
					cnt_q        <= cnt_q + 1'b1;
					if (cnt_q == LastAddr) begin
						cnt_q   <= LastRowAddr;
						state_q <= BLANK;
					end
				end
				BLANK: begin
					// The last copied cell is written back before blanking starts.
					if (!copy_v_s1) begin
						cnt_q <= cnt_q + 1'b1;
						if (cnt_q == LastAddr) begin
							out_valid_q     <= 1'b1;
							cursor_offset_q <= OFFS_W'(cur_addr);
							cell_data_q     <= '0;
							scrolled_q      <= 1'b1;
							state_q         <= IDLE;
						end
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	// A beat is taken only when the result register is free for its answer.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |-> (!out_valid_q || out_ready))
		else $error("input taken while result register is occupied");

	assert property (@(posedge clk) disable iff (!arst_n)
		copy_v_s1 |-> (state_q == COPY || state_q == BLANK))
		else $error("scroll copy write pending outside scroll");

	assert property (@(posedge clk) disable iff (!arst_n)
		(col_q < CW'(COLS)) && (row_q < RW'(ROWS)))
		else $error("cursor outside the screen");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == READ) |-> $past(in_valid && in_ready && cmd == CMD_READ))
		else $error("read state without a read beat");

	assert property (@(posedge clk) disable iff (!arst_n)
		(copy_v_s1 && mem_we) |-> (mem_waddr == copy_addr_s1))
		else $error("scroll copy write lost");

endmodule

// ----- design/text_console_char_writer_core.sv -----
// Top level of the text console character writer.
`timescale 1ns / 1ps

// A screen of COLS x ROWS cells (attribute byte over glyph byte) with a cursor,
// fed one command per input beat and answering each with one result beat.
// Printable characters and the cursor controls (backspace, tab, newline,
// carriage return) that do not scroll, and unknown commands, are finished in
// the cycle they are accepted, so they run at one item per cycle while
// out_ready is high; a cell read goes through the READ state because of the
// registered memory read. A clear command sweeps the single write port of the
// screen memory over every cell before its result. In a print that scrolls,
// each copied cell takes one read and one write through the two memory ports,
// then the bottom line is blanked. After reset the screen memory is filled
// with blank cells (attribute 0x0F) in a pass during which in_ready stays low.
// The attribute register accepts a write in every cycle.
module text_console_char_writer_core
	import tcw_pkg::*;
#(
	parameter int COLS = COLS_DEFAULT,
	parameter int ROWS = ROWS_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        cmd,
	input  logic [CHAR_W-1:0] char_code,
	input  logic [IDX_W-1:0]  cell_index,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [OFFS_W-1:0] cursor_offset,
	output logic [CELL_W-1:0] cell_data,
	output logic              scrolled,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [ATTR_W-1:0] text_attribute
);

	localparam int CellCount = COLS * ROWS;
	localparam int AW = $clog2(CellCount);

	logic [ATTR_W-1:0] attr_q;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [CELL_W-1:0] mem_wdata;
	logic              mem_re;
	logic [AW-1:0]     mem_raddr;
	logic [CELL_W-1:0] mem_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= RESET_ATTR;
		end else if (cfg_valid && cfg_ready) begin
			attr_q <= text_attribute;
		end
	end

	tcw_ctrl #(
		.COLS (COLS),
		.ROWS (ROWS),
		.AW   (AW)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.cmd           (cmd),
		.char_code     (char_code),
		.cell_index    (cell_index),
		.attr          (attr_q),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.cursor_offset (cursor_offset),
		.cell_data     (cell_data),
		.scrolled      (scrolled),
		.mem_we        (mem_we),
		.mem_waddr     (mem_waddr),
		.mem_wdata     (mem_wdata),
		.mem_re        (mem_re),
		.mem_raddr     (mem_raddr),
		.mem_rdata     (mem_rdata)
	);

	tcw_screen_ram #(
		.DEPTH (CellCount),
		.AW    (AW)
	) u_screen_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule
